// ===== hw/rtl/countdown_delay_table_unit_assert.svh =====
// Assertion macros for the countdown delay table.
`ifndef COUNTDOWN_DELAY_TABLE_UNIT_ASSERT_SVH
`define COUNTDOWN_DELAY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CDT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cdt_pkg.sv =====
package cdt_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int TASK_W    = 6;
	localparam int TIME_W    = 31;
	localparam int TICKS_W   = 32;
	localparam int TASK_MAX  = 64;

	localparam logic [TIME_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_TIME  = 2'd1,
		CMD_DELAY = 2'd2,
		CMD_UNTIL = 2'd3
	} cmd_t;

	typedef enum logic {
		KIND_RELEASE = 1'b0,
		KIND_TIME    = 1'b1
	} kind_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic [TASK_W-1:0]          task_id;
		logic signed [TICKS_W-1:0]  ticks;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [TASK_W-1:0]  target_task;
		logic [TIME_W-1:0]  time_value;
		logic               last;
	} out_item_t;

endpackage

// ===== hw/rtl/countdown_delay_table_unit.sv =====
// Countdown delay table: one delay slot per task (only the first 64 slots can ever be
// loaded), a saturating tick counter, and a release beat for every slot that expires.
// A delay load is written straight into its slot and leaves the input ready. A time
// request or an immediate release holds off the input while the reply moves from a
// response register into the output register, and also while that register still
// holds an unaccepted beat. A tick walks the slot memory one slot per cycle, unless a
// held release stalls on the output side, through a read, decrement and write-back
// pipeline, so it holds off the input until the walk and the closing flush are done.
// The last release of a tick carries last; a tick that releases nothing gives no
// beat. Busy flags are cleared by reset; no clearing pass is needed.
`include "countdown_delay_table_unit_assert.svh"

module countdown_delay_table_unit
	import cdt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int LIVE = (SLOTS < TASK_MAX) ? SLOTS : TASK_MAX;
	localparam int IW   = $clog2(LIVE);
	localparam int CW   = $clog2(LIVE + 1);
	localparam logic [TASK_W:0] LIVE_LIM = (TASK_W + 1)'(LIVE);
	localparam logic [CW-1:0]   CNT_END  = CW'(LIVE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	logic [LIVE-1:0]    busy_q;
	logic [TIME_W-1:0]  tick_count_q;
	logic [CW-1:0]      rd_cnt_q;
	logic               valid_s1;
	logic [IW-1:0]      idx_s1;
	logic [TIME_W-1:0]  rdata_s1;
	logic               pend_valid_q;
	logic [IW-1:0]      pend_idx_q;
	out_item_t          resp_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [TIME_W-1:0]  mem [LIVE];

	logic               accept;
	logic               out_free;
	logic               neg;
	logic [TIME_W-1:0]  mag;
	logic               task_ok;
	logic               until_gt;
	logic [TIME_W-1:0]  until_diff;
	logic               load;
	logic [TIME_W-1:0]  load_val;
	logic               busy_s1;
	logic [TIME_W-1:0]  dec_s1;
	logic               rel_s1;
	logic               stall;
	logic               adv;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [TIME_W-1:0]  wr_data;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign neg        = in_item.ticks[TICKS_W-1];
	assign mag        = in_item.ticks[TIME_W-1:0];
	assign task_ok    = {1'b0, in_item.task_id} < LIVE_LIM;
	assign until_gt   = mag > tick_count_q;
	assign until_diff = mag - tick_count_q;

	always_comb begin
		load     = 1'b0;
		load_val = mag;
		case (in_item.cmd)
			CMD_DELAY: load = task_ok && !neg && (mag != '0);
			CMD_UNTIL: begin
				load     = task_ok && !neg && until_gt;
				load_val = until_diff;
			end
			default: load = 1'b0;
		endcase
	end

	assign busy_s1 = busy_q[idx_s1];
	assign dec_s1  = (rdata_s1 == '0) ? '0 : rdata_s1 - TIME_W'(1);
	assign rel_s1  = valid_s1 && busy_s1 && (rdata_s1 <= TIME_W'(1));
	assign stall   = rel_s1 && pend_valid_q && !out_free;
	assign adv     = (state_q == ST_WALK) && !stall;
	assign rd_en   = adv && (rd_cnt_q != CNT_END);
	assign rd_addr = rd_cnt_q[IW-1:0];

	assign wr_en   = (accept && load) || (adv && valid_s1 && busy_s1);
	assign wr_addr = (state_q == ST_WALK) ? idx_s1 : in_item.task_id[IW-1:0];
	assign wr_data = (state_q == ST_WALK) ? dec_s1 : load_val;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= '0;
			tick_count_q <= '0;
			rd_cnt_q     <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			resp_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.cmd == CMD_TICK) begin
							rd_cnt_q <= '0;
							valid_s1 <= 1'b0;
							state_q  <= ST_WALK;
						end else if (load) begin
							busy_q[in_item.task_id[IW-1:0]] <= 1'b1;
						end else begin
							resp_q.kind        <= (in_item.cmd == CMD_TIME) ? KIND_TIME
							                                                : KIND_RELEASE;
							resp_q.target_task <= in_item.task_id;
							resp_q.time_value  <= (in_item.cmd == CMD_TIME) ? tick_count_q
							                                                : '0;
							resp_q.last        <= 1'b1;
							state_q            <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= resp_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (!stall) begin
						if (rel_s1) begin
							busy_q[idx_s1] <= 1'b0;
							if (pend_valid_q) begin
								out_valid_q       <= 1'b1;
								out_q.kind        <= KIND_RELEASE;
								out_q.target_task <= TASK_W'(pend_idx_q);
								out_q.time_value  <= '0;
								out_q.last        <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_idx_q   <= idx_s1;
						end
						valid_s1 <= rd_en;
						idx_s1   <= rd_addr;
						if (rd_en) begin
							rd_cnt_q <= rd_cnt_q + CW'(1);
						end
						if (!valid_s1 && (rd_cnt_q == CNT_END)) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_valid_q       <= 1'b1;
							out_q.kind        <= KIND_RELEASE;
							out_q.target_task <= TASK_W'(pend_idx_q);
							out_q.time_value  <= '0;
							out_q.last        <= 1'b1;
							pend_valid_q      <= 1'b0;
						end
						if (tick_count_q != COUNT_MAX) begin
							tick_count_q <= tick_count_q + TIME_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held release only lives inside a tick
	`CDT_ASSERT_NOW(a_pend_in_tick, pend_valid_q,
		(state_q == ST_WALK) || (state_q == ST_FLUSH), "held release outside a tick")
	// walk write-back never collides with the look-ahead read
	`CDT_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr,
		"write-back and read hit the same slot")
	// tick counter only moves up, and only when a tick finishes
	`CDT_ASSERT_NEXT(a_tick_mono, state_q != ST_FLUSH, tick_count_q == $past(tick_count_q),
		"tick counter moved outside tick completion")

endmodule

// ===== tb/sv/countdown_delay_table_unit_test.sv =====
`timescale 1ns / 1ps

module countdown_delay_table_unit_test;
	import cdt_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 120;

	class wake_tracker;
		logic              slot_busy [TASK_MAX];
		logic [TIME_W-1:0] slot_left [TASK_MAX];
		logic [TIME_W-1:0] tick_now;
		out_item_t         due_beats [$];
		int                mismatches;

		function new();
			foreach (slot_busy[i]) begin
				slot_busy[i] = 1'b0;
				slot_left[i] = '0;
			end
			tick_now = '0;
			mismatches = 0;
		endfunction

		function void push_beat(kind_t k, logic [TASK_W-1:0] t, logic [TIME_W-1:0] tv,
				logic lst);
			out_item_t b;
			b.kind = k;
			b.target_task = t;
			b.time_value = tv;
			b.last = lst;
			due_beats.push_back(b);
		endfunction

		function void load_or_release(logic [TASK_W-1:0] t, logic load,
				logic [TIME_W-1:0] left);
			if (load) begin
				slot_busy[t] = 1'b1;
				slot_left[t] = left;
			end else begin
				push_beat(KIND_RELEASE, t, '0, 1'b1);
			end
		endfunction

		function void note_request(in_item_t it);
			logic [31:0] raw;
			int          expired [$];
			raw = it.ticks;
			case (it.cmd)
				CMD_TICK: begin
					for (int i = 0; i < TASK_MAX; i++) begin
						if (slot_busy[i]) begin
							if (slot_left[i] != 0)
								slot_left[i] = slot_left[i] - 1'b1;
							if (slot_left[i] == 0) begin
								slot_busy[i] = 1'b0;
								expired.push_back(i);
							end
						end
					end
					foreach (expired[k])
						push_beat(KIND_RELEASE, TASK_W'(expired[k]), '0,
							k == expired.size() - 1);
					if (tick_now != COUNT_MAX)
						tick_now = tick_now + 1'b1;
				end
				CMD_TIME: push_beat(KIND_TIME, it.task_id, tick_now, 1'b1);
				CMD_DELAY: load_or_release(it.task_id, !raw[31] && raw != 0, raw[TIME_W-1:0]);
				default: load_or_release(it.task_id, !raw[31] && raw[TIME_W-1:0] > tick_now,
					raw[TIME_W-1:0] - tick_now);
			endcase
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			if (due_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: kind=%0d task=%0d time=%0d last=%0d",
						got.kind, got.target_task, got.time_value, got.last);
				return;
			end
			want = due_beats.pop_front();
			if (got.kind !== want.kind || got.target_task !== want.target_task ||
					got.time_value !== want.time_value || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp kind=%0d task=%0d time=%0d last=%0d,",
						" got kind=%0d task=%0d time=%0d last=%0d"},
						want.kind, want.target_task, want.time_value, want.last,
						got.kind, got.target_task, got.time_value, got.last);
			end
		endfunction

		function int pending();
			return due_beats.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	wake_tracker tracker;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          hold_len;
	int          cycles;

	countdown_delay_table_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_beat(out_item);
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				hold_len--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic in_item_t make_request(cmd_t c, logic [TASK_W-1:0] t, logic [31:0] v);
		in_item_t it;
		it.cmd = c;
		it.task_id = t;
		it.ticks = v;
		return it;
	endfunction

	function automatic in_item_t random_request();
		int unsigned       pick;
		int unsigned       mode;
		logic [TASK_W-1:0] t;
		logic [31:0]       v;
		pick = $urandom_range(99);
		mode = $urandom_range(9);
		t = $urandom_range(1) ? TASK_W'($urandom_range(7)) : TASK_W'($urandom_range(63));
		v = $urandom;
		if (pick < 35)
			return make_request(CMD_TICK, t, v);
		if (pick < 45)
			return make_request(CMD_TIME, t, v);
		if (pick < 75) begin
			if (mode < 6)
				v = $urandom_range(6, 1);
			else if (mode < 8)
				v = 32'(-int'($urandom_range(3)));
			else if (mode == 8)
				v = {1'b0, v[30:0]};
			return make_request(CMD_DELAY, t, v);
		end
		if (mode < 6)
			v = {1'b0, tracker.tick_now} + $urandom_range(6, 1);
		else if (mode < 8)
			v = {1'b0, tracker.tick_now} - $urandom_range(2);
		return make_request(CMD_UNTIL, t, v);
	endfunction

	task automatic send_request(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(it);
	endtask

	task automatic wait_all_released();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	task automatic send_random(int n);
		repeat (n)
			send_request(random_request());
	endtask

	initial begin
		tracker = new();
		cycles = 0;
		hold_len = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(make_request(CMD_TIME, 6'd0, 32'd0));
		send_request(make_request(CMD_DELAY, 6'd0, 32'd1));
		send_request(make_request(CMD_DELAY, 6'd63, 32'h7FFF_FFFF));
		send_request(make_request(CMD_DELAY, 6'd5, 32'd0));
		send_request(make_request(CMD_DELAY, 6'd6, 32'h8000_0000));
		send_request(make_request(CMD_DELAY, 6'd7, 32'hFFFF_FFFF));
		send_request(make_request(CMD_TICK, 6'd0, 32'hFFFF_FFFF));
		send_request(make_request(CMD_TICK, 6'd63, 32'd0));
		send_request(make_request(CMD_UNTIL, 6'd10, 32'd2));
		send_request(make_request(CMD_UNTIL, 6'd11, 32'd4));
		send_request(make_request(CMD_UNTIL, 6'd12, 32'h8000_0000));
		send_request(make_request(CMD_UNTIL, 6'd13, 32'h7FFF_FFFF));
		// already waiting: released now, old entry kept
		send_request(make_request(CMD_DELAY, 6'd11, 32'd0));
		send_request(make_request(CMD_DELAY, 6'd20, 32'd3));
		send_request(make_request(CMD_DELAY, 6'd20, 32'd1));
		send_request(make_request(CMD_DELAY, 6'd21, 32'd1));
		send_request(make_request(CMD_TICK, 6'd42, 32'h5555_AAAA));
		send_request(make_request(CMD_TICK, 6'd21, 32'hAAAA_5555));
		send_request(make_request(CMD_TIME, 6'd63, 32'h7FFF_FFFF));
		send_request(make_request(CMD_UNTIL, 6'd2, 32'd0));
		send_request(make_request(CMD_TIME, 6'd42, 32'h8000_0000));
		wait_all_released();

		// no idling, with a long output hold-off so the block backs up
		hold_len = 300;
		repeat (6)
			send_request(make_request(CMD_TIME, TASK_W'($urandom_range(63)), $urandom));
		send_random(12);
		wait_all_released();

		tx_idle_pct = 83;
		send_random(18);
		wait_all_released();

		tx_idle_pct = 0;
		rx_stall_pct = 83;
		for (int t = 0; t < TASK_MAX; t++)
			send_request(make_request(CMD_DELAY, TASK_W'(t), 32'd1));
		send_request(make_request(CMD_TICK, 6'd0, $urandom));
		send_random(18);
		wait_all_released();

		tx_idle_pct = 27;
		rx_stall_pct = 27;
		send_random(18);
		wait_all_released();

		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.mismatches += tracker.pending();
		if (tracker.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cdt_pkg.sv
hw/rtl/countdown_delay_table_unit.sv
tb/sv/countdown_delay_table_unit_test.sv
